// ===== rtl/tpfj_pkg.sv =====
`default_nettype none

package tpfj_pkg;

    localparam int FRAC     = 16;
    localparam int SAT_W    = 17;
    localparam int QB       = 32;
    localparam int DIV_NW   = QB + FRAC + 1;
    localparam int DIV_LAT  = QB + 2;
    localparam int PIPE_LAT = 4 * DIV_LAT + 8;

    typedef logic signed [31:0] t_q;
    typedef logic signed [33:0] t_wide;

    localparam t_q Q_MAX = 32'sh7fffffff;
    localparam t_q Q_MIN = 32'sh80000000;
    localparam t_q ONE   = 32'sd1 <<< FRAC;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_WATER_GRAV = 3'd0;
    localparam t_cfg_idx REG_OIL_GRAV   = 3'd1;
    localparam t_cfg_idx REG_GAS_GRAV   = 3'd2;
    localparam t_cfg_idx REG_WATER_VIS  = 3'd3;
    localparam t_cfg_idx REG_OIL_VIS    = 3'd4;
    localparam t_cfg_idx REG_GAS_VIS    = 3'd5;
    localparam t_cfg_idx REG_VELOCITY   = 3'd6;
    localparam t_cfg_idx REG_ORDER      = 3'd7;

    localparam logic [1:0] ORD_FLUX = 2'd0;
    localparam logic [1:0] ORD_JAC  = 2'd1;

    typedef struct packed {
        logic [SAT_W-1:0] water_sat;
        logic [SAT_W-1:0] oil_sat;
    } t_flux_req;

    typedef struct packed {
        t_q water_flux;
        t_q oil_flux;
        t_q dwf_dsw;
        t_q dwf_dso;
        t_q dof_dsw;
        t_q dof_dso;
        t_q d2wf_ww;
        t_q d2wf_wo;
        t_q d2wf_oo;
        t_q d2of_ww;
        t_q d2of_wo;
        t_q d2of_oo;
    } t_flux_rsp;

    function automatic t_wide ext34(input t_q x);
        return t_wide'(x);
    endfunction

    function automatic t_q sat32(input t_wide x);
        if (x > t_wide'(Q_MAX)) return Q_MAX;
        if (x < t_wide'(Q_MIN)) return Q_MIN;
        return $signed(x[31:0]);
    endfunction

    function automatic t_q fmul(input t_q a, input t_q b);
        logic signed [63:0] p;
        logic [63:0]        m;
        logic [63:0]        r;
        p = 64'(a) * 64'(b);
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        if (!p[63]) begin
            if (r > 64'h7fffffff) return Q_MAX;
            return $signed(r[31:0]);
        end
        if (r > 64'h80000000) return Q_MIN;
        return $signed(32'd0 - r[31:0]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/three_phase_flux_jet.sv =====
// Three-phase fractional flow with gravity, fixed point Q16.16.
// Request channel: i_req_valid / o_req_stall carry water and oil saturation
// (Q1.16); a request is taken on a clock edge with valid high and stall low.
// Response channel: o_rsp_valid / i_rsp_stall carry both fluxes, the 2x2
// Jacobian and the six distinct second derivatives, saturated to 32 bits.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx; write only
// while no request is in flight.
// Throughput: one request per cycle while i_rsp_stall does not hold the
// response. The depth is four chained 34-stage dividers (mobility, fractional
// weight, first and second derivative quotients) with the multiply and sum
// stages between them.
// Reset (synchronous, active low) empties the pipeline and loads gravities and
// velocity 0, viscosities 1.0 and full derivative order.
// While the response is held by i_rsp_stall the whole pipeline freezes and
// o_req_stall is raised; nothing is lost or repeated.
`default_nettype none

module three_phase_flux_jet (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  tpfj_pkg::t_flux_req  i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output tpfj_pkg::t_flux_rsp  o_rsp,
    input  logic                 i_cfg_we,
    input  tpfj_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    typedef struct packed {
        tpfj_pkg::t_q lk;
        tpfj_pkg::t_q tw;
        tpfj_pkg::t_q to;
    } t_car_c;

    typedef struct packed {
        tpfj_pkg::t_q       lk;
        tpfj_pkg::t_q       tw;
        tpfj_pkg::t_q       to;
        tpfj_pkg::t_q       f_w;
        tpfj_pkg::t_q       f_o;
        tpfj_pkg::t_q [3:0] g;
    } t_car_e;

    typedef struct packed {
        tpfj_pkg::t_q          tw;
        tpfj_pkg::t_q          to;
        tpfj_pkg::t_q  [5:0]   r;
        tpfj_pkg::t_wide [5:0] s;
    } t_car_g;

    function automatic tpfj_pkg::t_q to_q(input logic [tpfj_pkg::SAT_W-1:0] s);
        logic [tpfj_pkg::SAT_W+tpfj_pkg::FRAC:0] t;
        t = (tpfj_pkg::SAT_W+tpfj_pkg::FRAC+1)'({s, {tpfj_pkg::FRAC{1'b0}}})
            + (tpfj_pkg::SAT_W+tpfj_pkg::FRAC+1)'(32768);
        return $signed(32'(t >> 16));
    endfunction

    // configuration
    tpfj_pkg::t_q r_grav_w, r_grav_o, r_grav_g, r_vel;
    logic [30:0]  r_vis_w, r_vis_o, r_vis_g;
    logic [1:0]   r_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_w <= '0;
            r_grav_o <= '0;
            r_grav_g <= '0;
            r_vis_w  <= 31'(tpfj_pkg::ONE);
            r_vis_o  <= 31'(tpfj_pkg::ONE);
            r_vis_g  <= 31'(tpfj_pkg::ONE);
            r_vel    <= '0;
            r_ord    <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpfj_pkg::REG_WATER_GRAV: r_grav_w <= $signed(i_cfg_data);
                tpfj_pkg::REG_OIL_GRAV:   r_grav_o <= $signed(i_cfg_data);
                tpfj_pkg::REG_GAS_GRAV:   r_grav_g <= $signed(i_cfg_data);
                tpfj_pkg::REG_WATER_VIS:  r_vis_w  <= i_cfg_data[30:0];
                tpfj_pkg::REG_OIL_VIS:    r_vis_o  <= i_cfg_data[30:0];
                tpfj_pkg::REG_GAS_VIS:    r_vis_g  <= i_cfg_data[30:0];
                tpfj_pkg::REG_VELOCITY:   r_vel    <= $signed(i_cfg_data);
                tpfj_pkg::REG_ORDER:      r_ord    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    tpfj_pkg::t_q w_den_w, w_den_o, w_den_g;
    assign w_den_w = $signed({1'b0, r_vis_w});
    assign w_den_o = $signed({1'b0, r_vis_o});
    assign w_den_g = $signed({1'b0, r_vis_g});

    // terms that follow from configuration alone, free running
    tpfj_pkg::t_q w_iw, w_io, w_igp;
    tpfj_pkg::t_q r_dwo, r_dwg, r_dow, r_dog, r_ng;
    tpfj_pkg::t_q r_bw, r_bo, r_twsw, r_toso, r_p_wo, r_p_ow, r_twso, r_tosw;

    tpfj_div u_div_iw (.i_clk, .i_en(1'b1), .i_num(tpfj_pkg::ONE), .i_den(w_den_w),
                       .o_quo(w_iw));
    tpfj_div u_div_io (.i_clk, .i_en(1'b1), .i_num(tpfj_pkg::ONE), .i_den(w_den_o),
                       .o_quo(w_io));
    tpfj_div u_div_ig (.i_clk, .i_en(1'b1), .i_num(tpfj_pkg::ONE), .i_den(w_den_g),
                       .o_quo(w_igp));

    always_ff @(posedge i_clk) begin
        r_dwo  <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_grav_w) - tpfj_pkg::ext34(r_grav_o));
        r_dwg  <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_grav_w) - tpfj_pkg::ext34(r_grav_g));
        r_dow  <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_grav_o) - tpfj_pkg::ext34(r_grav_w));
        r_dog  <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_grav_o) - tpfj_pkg::ext34(r_grav_g));
        r_ng   <= -w_igp;
        r_bw   <= tpfj_pkg::sat32(tpfj_pkg::ext34(w_iw) + tpfj_pkg::ext34(r_ng));
        r_bo   <= tpfj_pkg::sat32(tpfj_pkg::ext34(w_io) + tpfj_pkg::ext34(r_ng));
        r_twsw <= tpfj_pkg::fmul(r_dwg, r_ng);
        r_toso <= tpfj_pkg::fmul(r_dog, r_ng);
        r_p_wo <= tpfj_pkg::fmul(r_dwo, w_io);
        r_p_ow <= tpfj_pkg::fmul(r_dow, w_iw);
        r_twso <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_p_wo) + tpfj_pkg::ext34(r_twsw));
        r_tosw <= tpfj_pkg::sat32(tpfj_pkg::ext34(r_p_ow) + tpfj_pkg::ext34(r_toso));
    end

    // pipeline control
    logic                          w_en;
    logic [tpfj_pkg::PIPE_LAT-1:0] r_vld;

    assign w_en        = !(r_vld[tpfj_pkg::PIPE_LAT-1] && i_rsp_stall);
    assign o_req_stall = !w_en;
    assign o_rsp_valid = r_vld[tpfj_pkg::PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[tpfj_pkg::PIPE_LAT-2:0], i_req_valid};
        end
    end

    // stage A: saturations
    tpfj_pkg::t_q n_sw, n_so;
    tpfj_pkg::t_q r_a_sw, r_a_so, r_a_sg;

    assign n_sw = to_q(i_req.water_sat);
    assign n_so = to_q(i_req.oil_sat);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sw <= n_sw;
            r_a_so <= n_so;
            r_a_sg <= tpfj_pkg::ONE - n_sw - n_so;
        end
    end

    tpfj_pkg::t_q w_lkw, w_lko, w_lkg;
    tpfj_div u_div_lkw (.i_clk, .i_en(w_en), .i_num(r_a_sw), .i_den(w_den_w), .o_quo(w_lkw));
    tpfj_div u_div_lko (.i_clk, .i_en(w_en), .i_num(r_a_so), .i_den(w_den_o), .o_quo(w_lko));
    tpfj_div u_div_lkg (.i_clk, .i_en(w_en), .i_num(r_a_sg), .i_den(w_den_g), .o_quo(w_lkg));

    // stage B: total mobility and gravity products
    tpfj_pkg::t_q       r_b_lk, r_b_lkw, r_b_lko;
    tpfj_pkg::t_q [3:0] r_b_m;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_lk   <= tpfj_pkg::sat32(tpfj_pkg::ext34(w_lkw) + tpfj_pkg::ext34(w_lko)
                                        + tpfj_pkg::ext34(w_lkg));
            r_b_lkw  <= w_lkw;
            r_b_lko  <= w_lko;
            r_b_m[0] <= tpfj_pkg::fmul(w_lko, r_dwo);
            r_b_m[1] <= tpfj_pkg::fmul(w_lkg, r_dwg);
            r_b_m[2] <= tpfj_pkg::fmul(w_lkw, r_dow);
            r_b_m[3] <= tpfj_pkg::fmul(w_lkg, r_dog);
        end
    end

    tpfj_pkg::t_q w_gw, w_go;
    tpfj_div u_div_gw (.i_clk, .i_en(w_en), .i_num(r_b_lkw), .i_den(r_b_lk), .o_quo(w_gw));
    tpfj_div u_div_go (.i_clk, .i_en(w_en), .i_num(r_b_lko), .i_den(r_b_lk), .o_quo(w_go));

    // stage C: transport terms, held until the weights arrive
    t_car_c n_c;
    t_car_c r_dc [tpfj_pkg::DIV_LAT];

    always_comb begin
        n_c.lk = r_b_lk;
        n_c.tw = tpfj_pkg::sat32(tpfj_pkg::ext34(r_vel) + tpfj_pkg::ext34(r_b_m[0])
                                 + tpfj_pkg::ext34(r_b_m[1]));
        n_c.to = tpfj_pkg::sat32(tpfj_pkg::ext34(r_vel) + tpfj_pkg::ext34(r_b_m[2])
                                 + tpfj_pkg::ext34(r_b_m[3]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dc[0] <= n_c;
            for (int k = 1; k < tpfj_pkg::DIV_LAT; k++) begin
                r_dc[k] <= r_dc[k-1];
            end
        end
    end

    // stage D: products of the weights
    t_car_c             w_c;
    tpfj_pkg::t_q [3:0] r_d_p;
    t_car_e             r_d_e;

    assign w_c = r_dc[tpfj_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_p[0]   <= tpfj_pkg::fmul(w_gw, r_bw);
            r_d_p[1]   <= tpfj_pkg::fmul(w_gw, r_bo);
            r_d_p[2]   <= tpfj_pkg::fmul(w_go, r_bw);
            r_d_p[3]   <= tpfj_pkg::fmul(w_go, r_bo);
            r_d_e.lk   <= w_c.lk;
            r_d_e.tw   <= w_c.tw;
            r_d_e.to   <= w_c.to;
            r_d_e.f_w  <= tpfj_pkg::fmul(w_gw, w_c.tw);
            r_d_e.f_o  <= tpfj_pkg::fmul(w_go, w_c.to);
            r_d_e.g[0] <= tpfj_pkg::fmul(w_gw, r_twsw);
            r_d_e.g[1] <= tpfj_pkg::fmul(w_gw, r_twso);
            r_d_e.g[2] <= tpfj_pkg::fmul(w_go, r_tosw);
            r_d_e.g[3] <= tpfj_pkg::fmul(w_go, r_toso);
        end
    end

    // stage E: first derivative numerators
    tpfj_pkg::t_q r_e_n [4];
    t_car_e       r_de  [tpfj_pkg::DIV_LAT+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_n[0] <= tpfj_pkg::sat32(tpfj_pkg::ext34(w_iw) - tpfj_pkg::ext34(r_d_p[0]));
            r_e_n[1] <= tpfj_pkg::sat32(-tpfj_pkg::ext34(r_d_p[1]));
            r_e_n[2] <= tpfj_pkg::sat32(-tpfj_pkg::ext34(r_d_p[2]));
            r_e_n[3] <= tpfj_pkg::sat32(tpfj_pkg::ext34(w_io) - tpfj_pkg::ext34(r_d_p[3]));
            r_de[0]  <= r_d_e;
            for (int k = 1; k <= tpfj_pkg::DIV_LAT; k++) begin
                r_de[k] <= r_de[k-1];
            end
        end
    end

    tpfj_pkg::t_q w_z [4];
    for (genvar g = 0; g < 4; g++) begin : g_div_z
        tpfj_div u_div (.i_clk, .i_en(w_en), .i_num(r_e_n[g]), .i_den(r_de[0].lk),
                        .o_quo(w_z[g]));
    end

    // stage F: products of the first derivative quotients
    t_car_e             w_e;
    tpfj_pkg::t_q [3:0] r_f_zt;
    tpfj_pkg::t_q [7:0] r_f_bz;
    tpfj_pkg::t_q [7:0] r_f_zs;
    t_car_e             r_f_e;

    assign w_e = r_de[tpfj_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_zt[0] <= tpfj_pkg::fmul(w_z[0], w_e.tw);
            r_f_zt[1] <= tpfj_pkg::fmul(w_z[1], w_e.tw);
            r_f_zt[2] <= tpfj_pkg::fmul(w_z[2], w_e.to);
            r_f_zt[3] <= tpfj_pkg::fmul(w_z[3], w_e.to);
            r_f_bz[0] <= tpfj_pkg::fmul(r_bw, w_z[0]);
            r_f_bz[1] <= tpfj_pkg::fmul(r_bo, w_z[0]);
            r_f_bz[2] <= tpfj_pkg::fmul(r_bw, w_z[1]);
            r_f_bz[3] <= tpfj_pkg::fmul(r_bo, w_z[1]);
            r_f_bz[4] <= tpfj_pkg::fmul(r_bw, w_z[2]);
            r_f_bz[5] <= tpfj_pkg::fmul(r_bo, w_z[2]);
            r_f_bz[6] <= tpfj_pkg::fmul(r_bw, w_z[3]);
            r_f_bz[7] <= tpfj_pkg::fmul(r_bo, w_z[3]);
            r_f_zs[0] <= tpfj_pkg::fmul(w_z[0], r_twsw);
            r_f_zs[1] <= tpfj_pkg::fmul(w_z[0], r_twso);
            r_f_zs[2] <= tpfj_pkg::fmul(w_z[1], r_twsw);
            r_f_zs[3] <= tpfj_pkg::fmul(w_z[1], r_twso);
            r_f_zs[4] <= tpfj_pkg::fmul(w_z[2], r_tosw);
            r_f_zs[5] <= tpfj_pkg::fmul(w_z[2], r_toso);
            r_f_zs[6] <= tpfj_pkg::fmul(w_z[3], r_tosw);
            r_f_zs[7] <= tpfj_pkg::fmul(w_z[3], r_toso);
            r_f_e     <= w_e;
        end
    end

    // stage G: Jacobian, second derivative numerators and partial sums
    t_car_g       n_g;
    tpfj_pkg::t_q n_h [6];
    tpfj_pkg::t_q r_g_h [6];
    tpfj_pkg::t_q r_g_lk;
    t_car_g       r_dg [tpfj_pkg::DIV_LAT+1];

    always_comb begin
        n_g.tw   = r_f_e.tw;
        n_g.to   = r_f_e.to;
        n_g.r[0] = r_f_e.f_w;
        n_g.r[1] = r_f_e.f_o;
        for (int k = 0; k < 4; k++) begin
            n_g.r[k+2] = tpfj_pkg::sat32(tpfj_pkg::ext34(r_f_zt[k])
                                         + tpfj_pkg::ext34(r_f_e.g[k]));
        end
        n_g.s[0] = tpfj_pkg::ext34(r_f_zs[0]) <<< 1;
        n_g.s[1] = tpfj_pkg::ext34(r_f_zs[1]) + tpfj_pkg::ext34(r_f_zs[2]);
        n_g.s[2] = tpfj_pkg::ext34(r_f_zs[3]) <<< 1;
        n_g.s[3] = tpfj_pkg::ext34(r_f_zs[4]) <<< 1;
        n_g.s[4] = tpfj_pkg::ext34(r_f_zs[6]) + tpfj_pkg::ext34(r_f_zs[5]);
        n_g.s[5] = tpfj_pkg::ext34(r_f_zs[7]) <<< 1;
        n_h[0] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[0]) <<< 1));
        n_h[1] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[2]) + tpfj_pkg::ext34(r_f_bz[1])));
        n_h[2] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[3]) <<< 1));
        n_h[3] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[4]) <<< 1));
        n_h[4] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[6]) + tpfj_pkg::ext34(r_f_bz[5])));
        n_h[5] = tpfj_pkg::sat32(-(tpfj_pkg::ext34(r_f_bz[7]) <<< 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_h   <= n_h;
            r_g_lk  <= r_f_e.lk;
            r_dg[0] <= n_g;
            for (int k = 1; k <= tpfj_pkg::DIV_LAT; k++) begin
                r_dg[k] <= r_dg[k-1];
            end
        end
    end

    tpfj_pkg::t_q w_h [6];
    for (genvar g = 0; g < 6; g++) begin : g_div_h
        tpfj_div u_div (.i_clk, .i_en(w_en), .i_num(r_g_h[g]), .i_den(r_g_lk),
                        .o_quo(w_h[g]));
    end

    // stage H: second derivative products
    t_car_g             w_gc;
    tpfj_pkg::t_q [5:0] r_h_p;
    t_car_g             r_h_g;

    assign w_gc = r_dg[tpfj_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_h_p[k]   <= tpfj_pkg::fmul(w_h[k], w_gc.tw);
                r_h_p[k+3] <= tpfj_pkg::fmul(w_h[k+3], w_gc.to);
            end
            r_h_g <= w_gc;
        end
    end

    // output register
    logic                    w_jac, w_hess;
    tpfj_pkg::t_q [5:0]      w_sec;
    tpfj_pkg::t_flux_rsp     n_rsp;
    tpfj_pkg::t_flux_rsp     r_rsp;

    assign w_jac  = (r_ord != tpfj_pkg::ORD_FLUX);
    assign w_hess = (r_ord != tpfj_pkg::ORD_FLUX) && (r_ord != tpfj_pkg::ORD_JAC);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_sec[k] = tpfj_pkg::sat32(tpfj_pkg::ext34(r_h_p[k]) + r_h_g.s[k]);
        end
        n_rsp.water_flux = r_h_g.r[0];
        n_rsp.oil_flux   = r_h_g.r[1];
        n_rsp.dwf_dsw    = w_jac  ? r_h_g.r[2] : '0;
        n_rsp.dwf_dso    = w_jac  ? r_h_g.r[3] : '0;
        n_rsp.dof_dsw    = w_jac  ? r_h_g.r[4] : '0;
        n_rsp.dof_dso    = w_jac  ? r_h_g.r[5] : '0;
        n_rsp.d2wf_ww    = w_hess ? w_sec[0] : '0;
        n_rsp.d2wf_wo    = w_hess ? w_sec[1] : '0;
        n_rsp.d2wf_oo    = w_hess ? w_sec[2] : '0;
        n_rsp.d2of_ww    = w_hess ? w_sec[3] : '0;
        n_rsp.d2of_wo    = w_hess ? w_sec[4] : '0;
        n_rsp.d2of_oo    = w_hess ? w_sec[5] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/tpfj_div.sv =====
`default_nettype none

module tpfj_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  tpfj_pkg::t_q  i_num,
    input  tpfj_pkg::t_q  i_den,
    output tpfj_pkg::t_q  o_quo
);

    logic [31:0]                   w_ma;
    logic [31:0]                   w_mb;
    logic [tpfj_pkg::DIV_NW-1:0]   w_n;
    logic [32:0]                   w_d;
    logic [32:0]                   w_hi;
    logic                          w_zero;
    logic                          w_ovf;
    logic                          w_neg;

    logic [32:0]             r_rem  [tpfj_pkg::QB+1];
    logic [tpfj_pkg::QB-1:0] r_low  [tpfj_pkg::QB+1];
    logic [tpfj_pkg::QB-1:0] r_quo  [tpfj_pkg::QB+1];
    logic [32:0]             r_den  [tpfj_pkg::QB+1];
    logic                    r_neg  [tpfj_pkg::QB+1];
    logic                    r_sat  [tpfj_pkg::QB+1];
    logic                    r_sneg [tpfj_pkg::QB+1];
    tpfj_pkg::t_q            r_out;

    logic [33:0] w_t  [tpfj_pkg::QB];
    logic        w_ge [tpfj_pkg::QB];
    logic [31:0] w_q;
    tpfj_pkg::t_q n_out;

    assign w_ma   = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_mb   = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign w_n    = {w_ma, {(tpfj_pkg::FRAC+1){1'b0}}} + (tpfj_pkg::DIV_NW)'(w_mb);
    assign w_d    = {w_mb, 1'b0};
    assign w_hi   = 33'(w_n[tpfj_pkg::DIV_NW-1:tpfj_pkg::QB]);
    assign w_zero = (i_den == '0);
    assign w_ovf  = (w_hi >= w_d);
    assign w_neg  = i_num[31] ^ i_den[31];

    always_comb begin
        for (int k = 0; k < tpfj_pkg::QB; k++) begin
            w_t[k]  = {r_rem[k], r_low[k][tpfj_pkg::QB-1]};
            w_ge[k] = (w_t[k] >= {1'b0, r_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_hi;
            r_low[0]  <= w_n[tpfj_pkg::QB-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= w_d;
            r_neg[0]  <= w_neg;
            r_sat[0]  <= w_zero | w_ovf;
            r_sneg[0] <= w_zero ? i_num[31] : w_neg;
            for (int k = 0; k < tpfj_pkg::QB; k++) begin
                r_rem[k+1]  <= w_ge[k] ? 33'(w_t[k] - {1'b0, r_den[k]}) : w_t[k][32:0];
                r_low[k+1]  <= r_low[k] << 1;
                r_quo[k+1]  <= {r_quo[k][tpfj_pkg::QB-2:0], w_ge[k]};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_sat[k+1]  <= r_sat[k];
                r_sneg[k+1] <= r_sneg[k];
            end
            r_out <= n_out;
        end
    end

    assign w_q = r_quo[tpfj_pkg::QB];

    always_comb begin
        if (r_sat[tpfj_pkg::QB]) begin
            n_out = r_sneg[tpfj_pkg::QB] ? tpfj_pkg::Q_MIN : tpfj_pkg::Q_MAX;
        end else if (!r_neg[tpfj_pkg::QB]) begin
            n_out = (w_q > 32'h7fffffff) ? tpfj_pkg::Q_MAX : $signed(w_q);
        end else begin
            n_out = (w_q > 32'h80000000) ? tpfj_pkg::Q_MIN : $signed(32'd0 - w_q);
        end
    end

    assign o_quo = r_out;

endmodule

`default_nettype wire

// ===== dv/three_phase_flux_jet_tb.sv =====
`timescale 1ns / 1ps

module three_phase_flux_jet_tb;

    class flux_scoreboard;
        logic signed [63:0]       water_grav, oil_grav, gas_grav;
        logic signed [63:0]       water_vis, oil_vis, gas_vis, velocity;
        logic [1:0]               order;
        tpfj_pkg::t_flux_rsp      pending[$];
        int                       errors;

        function void reset_regs();
            water_grav = 0; oil_grav = 0; gas_grav = 0;
            water_vis = 65536; oil_vis = 65536; gas_vis = 65536;
            velocity = 0; order = 2;
        endfunction

        function void write_reg(tpfj_pkg::t_cfg_idx idx, logic [31:0] data);
            case (idx)
                tpfj_pkg::REG_WATER_GRAV: water_grav = $signed(data);
                tpfj_pkg::REG_OIL_GRAV:   oil_grav = $signed(data);
                tpfj_pkg::REG_GAS_GRAV:   gas_grav = $signed(data);
                tpfj_pkg::REG_WATER_VIS:  water_vis = {33'd0, data[30:0]};
                tpfj_pkg::REG_OIL_VIS:    oil_vis = {33'd0, data[30:0]};
                tpfj_pkg::REG_GAS_VIS:    gas_vis = {33'd0, data[30:0]};
                tpfj_pkg::REG_VELOCITY:   velocity = $signed(data);
                default:                  order = data[1:0];
            endcase
        endfunction

        function logic signed [63:0] clip(logic signed [63:0] x);
            if (x > 64'sh7fffffff) return 64'sh7fffffff;
            if (x < -64'sh80000000) return -64'sh80000000;
            return x;
        endfunction

        function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] p;
            logic [63:0]        m;
            p = a * b;
            m = p < 0 ? -p : p;
            m = (m + 64'd32768) >> 16;
            return clip(p < 0 ? -$signed(m) : $signed(m));
        endfunction

        function logic signed [63:0] qdiv(logic signed [63:0] a, logic signed [63:0] b);
            logic [63:0] ma, mb, q;
            if (b == 0) return a < 0 ? -64'sh80000000 : 64'sh7fffffff;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            q = ((ma << 17) + mb) / (2 * mb);
            if (q > (64'd1 << 40)) q = 64'd1 << 40;
            return clip(((a < 0) != (b < 0)) ? -$signed(q) : $signed(q));
        endfunction

        function void note_request(tpfj_pkg::t_flux_req rq);
            logic signed [63:0] sw, so, sg, lw, lo, lg, lt, dwo, dwg, dow, dog, tw, to, gw, go;
            logic signed [63:0] iw, io, ng, bw, bo, twsw, twso, tosw, toso;
            logic signed [63:0] zww, zwo, zow, zoo, h1, h2, h3, k1, k2, k3;
            logic signed [63:0] r[12];
            tpfj_pkg::t_flux_rsp x;
            sw = (({47'd0, rq.water_sat} << 16) + 32768) >> 16;
            so = (({47'd0, rq.oil_sat} << 16) + 32768) >> 16;
            sg = 65536 - sw - so;
            lw = qdiv(sw, water_vis); lo = qdiv(so, oil_vis); lg = qdiv(sg, gas_vis);
            lt = clip(lw + lo + lg);
            dwo = clip(water_grav - oil_grav); dwg = clip(water_grav - gas_grav);
            dow = clip(oil_grav - water_grav); dog = clip(oil_grav - gas_grav);
            tw = clip(velocity + qmul(lo, dwo) + qmul(lg, dwg));
            to = clip(velocity + qmul(lw, dow) + qmul(lg, dog));
            gw = qdiv(lw, lt); go = qdiv(lo, lt);
            foreach (r[i]) r[i] = 0;
            r[0] = qmul(gw, tw); r[1] = qmul(go, to);
            if (order >= 1) begin
                iw = qdiv(65536, water_vis); io = qdiv(65536, oil_vis);
                ng = -qdiv(65536, gas_vis);
                bw = clip(iw + ng); bo = clip(io + ng);
                twsw = qmul(dwg, ng);
                twso = clip(qmul(dwo, io) + qmul(dwg, ng));
                tosw = clip(qmul(dow, iw) + qmul(dog, ng));
                toso = qmul(dog, ng);
                zww = qdiv(clip(iw - qmul(gw, bw)), lt);
                zwo = qdiv(clip(-qmul(gw, bo)), lt);
                zow = qdiv(clip(-qmul(go, bw)), lt);
                zoo = qdiv(clip(io - qmul(go, bo)), lt);
                r[2] = clip(qmul(zww, tw) + qmul(gw, twsw));
                r[3] = clip(qmul(zwo, tw) + qmul(gw, twso));
                r[4] = clip(qmul(zow, to) + qmul(go, tosw));
                r[5] = clip(qmul(zoo, to) + qmul(go, toso));
                if (order >= 2) begin
                    h1 = qdiv(clip(-2 * qmul(bw, zww)), lt);
                    h2 = qdiv(clip(-(qmul(bw, zwo) + qmul(bo, zww))), lt);
                    h3 = qdiv(clip(-2 * qmul(bo, zwo)), lt);
                    k1 = qdiv(clip(-2 * qmul(bw, zow)), lt);
                    k2 = qdiv(clip(-(qmul(bw, zoo) + qmul(bo, zow))), lt);
                    k3 = qdiv(clip(-2 * qmul(bo, zoo)), lt);
                    r[6] = clip(qmul(h1, tw) + 2 * qmul(zww, twsw));
                    r[7] = clip(qmul(h2, tw) + qmul(zww, twso) + qmul(zwo, twsw));
                    r[8] = clip(qmul(h3, tw) + 2 * qmul(zwo, twso));
                    r[9] = clip(qmul(k1, to) + 2 * qmul(zow, tosw));
                    r[10] = clip(qmul(k2, to) + qmul(zoo, tosw) + qmul(zow, toso));
                    r[11] = clip(qmul(k3, to) + 2 * qmul(zoo, toso));
                end
            end
            x = {r[0][31:0], r[1][31:0], r[2][31:0], r[3][31:0], r[4][31:0], r[5][31:0],
                 r[6][31:0], r[7][31:0], r[8][31:0], r[9][31:0], r[10][31:0], r[11][31:0]};
            pending.push_back(x);
        endfunction

        function void check_response(tpfj_pkg::t_flux_rsp got);
            tpfj_pkg::t_flux_rsp want;
            logic [383:0] w, g;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", got);
                return;
            end
            want = pending.pop_front();
            w = want; g = got;
            for (int i = 0; i < 12; i++) begin
                if (w[383 - 32*i -: 32] !== g[383 - 32*i -: 32]) begin
                    errors++;
                    if (errors <= 10)
                        $display("field %0d: expected %h got %h", i,
                                 w[383 - 32*i -: 32], g[383 - 32*i -: 32]);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 0, i_rst_n = 0;
    logic                 i_req_valid = 0, i_rsp_stall = 0, i_cfg_we = 0;
    logic                 o_req_stall, o_rsp_valid;
    tpfj_pkg::t_flux_req  i_req = '0;
    tpfj_pkg::t_flux_rsp  o_rsp;
    tpfj_pkg::t_cfg_idx   i_cfg_idx = tpfj_pkg::REG_WATER_GRAV;
    logic [31:0]          i_cfg_data = '0;

    int idle_pct = 0, stall_pct = 0;
    int hold_cycles = 0;
    flux_scoreboard sb;

    three_phase_flux_jet u_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) sb.check_response(o_rsp);
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_rsp_stall <= 1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(logic [16:0] ws, logic [16:0] os);
        i_cfg_we <= 0;
        while ($urandom_range(99) < idle_pct) begin
            i_req_valid <= 0;
            @(negedge i_clk);
        end
        i_req_valid <= 1;
        i_req <= '{water_sat: ws, oil_sat: os};
        do @(posedge i_clk); while (o_req_stall);
        sb.note_request('{water_sat: ws, oil_sat: os});
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_req_valid <= 0;
        i_cfg_we <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (tpfj_pkg::PIPE_LAT + 20) @(negedge i_clk);
    endtask

    task automatic write_reg(tpfj_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        sb.write_reg(idx, data);
    endtask

    function automatic logic [16:0] rand_sat();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic random_regs();
        logic [31:0] v;
        for (int r = 0; r < 7; r++) begin
            v = $urandom();
            if (r >= tpfj_pkg::REG_WATER_VIS && r <= tpfj_pkg::REG_GAS_VIS) begin
                case ($urandom_range(3))
                    0: v = 32'd1;
                    1: v = 32'h7fffffff;
                    default: v = $urandom_range(32'h40000, 32'h1000);
                endcase
            end else if ($urandom_range(1)) begin
                v = $urandom_range(32'h40000) - 32'h20000;
            end
            write_reg(tpfj_pkg::t_cfg_idx'(r), v);
        end
        write_reg(tpfj_pkg::REG_ORDER, $urandom_range(3));
    endtask

    task automatic random_batch(int n);
        int mix;
        for (int k = 0; k < n; k++) begin
            mix = $urandom_range(3);
            if (mix == 0) begin
                idle_pct = 0; stall_pct = 0;
            end else if (mix == 1) begin
                idle_pct = 79; stall_pct = 0;
            end else if (mix == 2) begin
                idle_pct = 0; stall_pct = 79;
            end else begin
                idle_pct = 23; stall_pct = 23;
            end
            repeat (10) send_request(rand_sat(), rand_sat());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        send_request(17'd0, 17'd0);
        send_request(17'd65536, 17'd0);
        send_request(17'd0, 17'd65536);
        send_request(17'd32768, 17'd32768);
        send_request(17'd131071, 17'd131071);
        send_request(17'd21845, 17'd21845);
        send_request(17'd1, 17'd65535);
        drain();

        write_reg(tpfj_pkg::REG_WATER_GRAV, 32'h7fffffff);
        write_reg(tpfj_pkg::REG_OIL_GRAV, 32'h80000000);
        write_reg(tpfj_pkg::REG_GAS_GRAV, 32'h00010000);
        write_reg(tpfj_pkg::REG_WATER_VIS, 32'd1);
        write_reg(tpfj_pkg::REG_OIL_VIS, 32'hffffffff);
        write_reg(tpfj_pkg::REG_GAS_VIS, 32'h00008000);
        write_reg(tpfj_pkg::REG_VELOCITY, 32'h80000000);
        write_reg(tpfj_pkg::REG_ORDER, 32'(tpfj_pkg::ORD_JAC));
        send_request(17'd65536, 17'd0);
        send_request(17'd30000, 17'd20000);
        send_request(17'd0, 17'd0);
        drain();

        write_reg(tpfj_pkg::REG_ORDER, 32'(tpfj_pkg::ORD_FLUX));
        write_reg(tpfj_pkg::REG_WATER_VIS, 32'd0);
        write_reg(tpfj_pkg::REG_VELOCITY, 32'h7fffffff);
        send_request(17'd0, 17'd65536);
        send_request(17'd40000, 17'd40000);
        drain();

        write_reg(tpfj_pkg::REG_ORDER, 32'd3);
        write_reg(tpfj_pkg::REG_WATER_VIS, 32'h00010000);
        write_reg(tpfj_pkg::REG_OIL_VIS, 32'h00020000);
        write_reg(tpfj_pkg::REG_GAS_VIS, 32'h00030000);
        write_reg(tpfj_pkg::REG_WATER_GRAV, 32'h00001000);
        write_reg(tpfj_pkg::REG_OIL_GRAV, 32'hffff0000);
        write_reg(tpfj_pkg::REG_GAS_GRAV, 32'h00000000);
        write_reg(tpfj_pkg::REG_VELOCITY, 32'h00010000);
        send_request(17'd20000, 17'd20000);

        hold_cycles = 400;
        idle_pct = 0;
        repeat (200) send_request(rand_sat(), rand_sat());
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            random_regs();
            random_batch(10);
            drain();
        end

        idle_pct = 0; stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("three_phase_flux_jet: match");
        end else begin
            $display("three_phase_flux_jet: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("three_phase_flux_jet: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tpfj_pkg.sv
rtl/tpfj_div.sv
rtl/three_phase_flux_jet.sv
dv/three_phase_flux_jet_tb.sv
